// ----- src/assert_macros.svh -----
// Assertion macros shared by the allocatee RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define DNIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dnia assertion failed");

// Condition must never be seen out of reset
`define DNIA_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("dnia forbidden condition seen");

`endif

// ----- src/dnia_pkg.sv -----
// Shared constants, types and helpers of the node ID allocatee
package dnia_pkg;

  localparam int UID_BYTES           = 16;
  localparam int MAX_UID_PER_REQUEST = 6;

  localparam int OFF_W      = $clog2(UID_BYTES + 1);
  localparam int CNT_W      = $clog2(MAX_UID_PER_REQUEST + 1);
  localparam int RX_W       = 5;
  localparam int UID_IDX_W  = 4;
  localparam int UID_W      = 128;
  localparam int DELAY_W    = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [RX_W-1:0] RX_SAT = '1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PREFERRED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UID_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UID_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 3'd4;

  // Reset values of the configuration registers
  localparam logic [6:0]  PREFERRED_RST  = 7'd7;
  localparam logic [15:0] MIN_PERIOD_RST = 16'd1000;
  localparam logic [15:0] MAX_DELAY_RST  = 16'd400;

  typedef enum logic [2:0] {
    KIND_REQUEST   = 3'd0,
    KIND_ADVANCED  = 3'd1,
    KIND_RESET     = 3'd2,
    KIND_ALLOCATED = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;
    logic dec_delay;
    logic emit_start;
    logic emit_push;
    logic rx_update;
    logic mul;
    logic div;
    logic judge;
  } dnia_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic allocated;
    logic delay_gt1;
    logic is_tick;
    logic is_last;
    logic out_free;
    logic emit_last;
  } dnia_sts_t;

  // Pick one byte of the unique ID
  function automatic logic [7:0] uid_byte(input logic [UID_W-1:0] uid,
                                          input logic [UID_IDX_W-1:0] idx);
    uid_byte = uid[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ----- src/dnia_ctrl.sv -----
// Sequencing state machine of the node ID allocatee
`include "assert_macros.svh"

module dnia_ctrl import dnia_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dnia_sts_t sts_i,
  output dnia_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_EMIT,
    S_MUL,
    S_DIV,
    S_JUDGE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.allocated) begin
          state_d = S_IDLE;
        end else if (sts_i.is_tick) begin
          if (sts_i.delay_gt1) begin
            cmd_o.dec_delay = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.emit_start = 1'b1;
            state_d          = S_EMIT;
          end
        end else begin
          cmd_o.rx_update = 1'b1;
          state_d         = sts_i.is_last ? S_MUL : S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_push = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = sts_i.is_tick ? S_IDLE : S_JUDGE;
      end
      S_JUDGE: begin
        if (sts_i.out_free) begin
          cmd_o.judge = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `DNIA_ASSERT(a_mul_then_div, (state_q == S_MUL) |=> (state_q == S_DIV))
  `DNIA_ASSERT(a_emit_exit, ($past(state_q) == S_EMIT && state_q != S_EMIT) |-> (state_q == S_MUL))

endmodule

// ----- src/dnia_dp.sv -----
// Registers, delay arithmetic and result register of the node ID allocatee
`include "assert_macros.svh"

module dnia_dp import dnia_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dnia_cmd_t             cmd_i,
  output dnia_sts_t             sts_o,
  input  logic                  req_type_i,
  input  logic [7:0]            payload_byte_i,
  input  logic                  payload_last_i,
  input  logic                  source_anonymous_i,
  input  logic [15:0]           random_value_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            result_kind_o,
  output logic [7:0]            data_byte_o,
  output logic                  last_of_run_o,
  output logic [6:0]            assigned_node_id_o,
  output logic [OFF_W-1:0]      confirmed_offset_o
);

  // Configuration registers
  logic [6:0]       pref_q;
  logic [UID_W-1:0] uid_q;
  logic [15:0]      min_q;
  logic [15:0]      max_q;

  // Latched input item
  logic        type_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        anon_q;
  logic [15:0] rnd_q;

  // Allocation state
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [OFF_W-1:0]   uid_offset_q, uid_offset_d;
  logic               allocated_q, allocated_d;
  logic [6:0]         node_id_q, node_id_d;
  logic [RX_W-1:0]    rx_count_q, rx_count_d;
  logic               rx_match_q, rx_match_d;
  logic [7:0]         rx_first_q, rx_first_d;
  logic [CNT_W-1:0]   emit_idx_q, emit_idx_d;
  logic [31:0]        prod_q;

  // Result register
  logic               out_valid_q, out_valid_d;
  kind_e              kind_q, kind_d;
  logic [7:0]         data_q, data_d;
  logic               out_last_q, out_last_d;
  logic [6:0]         nid_q, nid_d;
  logic [OFF_W-1:0]   out_off_q, out_off_d;

  logic               out_free;

  // Number of unique ID bytes in a request
  logic [OFF_W-1:0] uid_left;
  logic [CNT_W-1:0] n_uid;

  always_comb begin
    uid_left = OFF_W'(UID_BYTES) - uid_offset_q;
    if (uid_offset_q >= OFF_W'(UID_BYTES)) begin
      n_uid = '0;
    end else if (uid_left > OFF_W'(MAX_UID_PER_REQUEST)) begin
      n_uid = CNT_W'(MAX_UID_PER_REQUEST);
    end else begin
      n_uid = uid_left[CNT_W-1:0];
    end
  end

  // Request byte for the current emit position
  logic [OFF_W-1:0] emit_pos;
  logic [7:0]       emit_byte;

  always_comb begin
    emit_pos = uid_offset_q + OFF_W'(emit_idx_q) - OFF_W'(1);
    if (emit_idx_q == '0) begin
      emit_byte = {pref_q, (uid_offset_q == '0)};
    end else begin
      emit_byte = uid_byte(uid_q, emit_pos[UID_IDX_W-1:0]);
    end
  end

  // Response byte comparison
  logic [RX_W-1:0] rx_pos;
  logic            rx_mismatch;

  always_comb begin
    rx_pos      = rx_count_q - RX_W'(1);
    rx_mismatch = (rx_count_q != '0) && (rx_pos < RX_W'(UID_BYTES)) &&
                  (uid_byte(uid_q, rx_pos[UID_IDX_W-1:0]) != byte_q);
  end

  // Delay draw: floor(product / 0xFFFF) by reciprocal add
  logic [32:0]        div_sum;
  logic [15:0]        div_quot;
  logic [DELAY_W-1:0] delay_draw;

  always_comb begin
    div_sum    = {1'b0, prod_q} + 33'(prod_q[31:16]) + 33'd1;
    div_quot   = div_sum[31:16];
    delay_draw = {1'b0, min_q} + {1'b0, div_quot};
  end

  // Judgment of a complete response
  kind_e              judge_kind;
  logic [OFF_W-1:0]   judge_off;
  logic [RX_W-1:0]    rx_uid_len;
  logic [DELAY_W-1:0] delay_short;

  always_comb begin
    rx_uid_len  = rx_count_q - RX_W'(1);
    delay_short = (delay_q > {1'b0, min_q}) ? (delay_q - {1'b0, min_q}) : '0;
    judge_off   = '0;
    if (anon_q) begin
      judge_kind = KIND_RESET;
    end else if (rx_count_q > RX_W'(UID_BYTES + 1)) begin
      judge_kind = KIND_MALFORMED;
    end else if (!rx_match_q) begin
      judge_kind = KIND_RESET;
    end else if (rx_uid_len < RX_W'(UID_BYTES)) begin
      judge_kind = KIND_ADVANCED;
      judge_off  = OFF_W'(rx_uid_len);
    end else begin
      judge_kind = KIND_ALLOCATED;
      judge_off  = uid_offset_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next values of state and result register
  always_comb begin
    delay_d      = delay_q;
    uid_offset_d = uid_offset_q;
    allocated_d  = allocated_q;
    node_id_d    = node_id_q;
    rx_count_d   = rx_count_q;
    rx_match_d   = rx_match_q;
    rx_first_d   = rx_first_q;
    emit_idx_d   = emit_idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    kind_d       = kind_q;
    data_d       = data_q;
    out_last_d   = out_last_q;
    nid_d        = nid_q;
    out_off_d    = out_off_q;

    if (cmd_i.dec_delay) begin
      delay_d = delay_q - DELAY_W'(1);
    end
    if (cmd_i.emit_start) begin
      emit_idx_d = '0;
    end
    if (cmd_i.emit_push) begin
      emit_idx_d  = emit_idx_q + CNT_W'(1);
      out_valid_d = 1'b1;
      kind_d      = KIND_REQUEST;
      data_d      = emit_byte;
      out_last_d  = (emit_idx_q == n_uid);
      nid_d       = '0;
      out_off_d   = uid_offset_q;
      if (emit_idx_q == n_uid) begin
        uid_offset_d = '0;
      end
    end
    if (cmd_i.rx_update) begin
      if (rx_count_q == '0) begin
        rx_first_d = byte_q;
      end
      if (rx_mismatch) begin
        rx_match_d = 1'b0;
      end
      if (rx_count_q != RX_SAT) begin
        rx_count_d = rx_count_q + RX_W'(1);
      end
    end
    if (cmd_i.div) begin
      delay_d = delay_draw;
    end
    if (cmd_i.judge) begin
      uid_offset_d = judge_off;
      rx_count_d   = '0;
      rx_match_d   = 1'b1;
      out_valid_d  = 1'b1;
      kind_d       = judge_kind;
      data_d       = '0;
      out_last_d   = 1'b1;
      nid_d        = '0;
      out_off_d    = judge_off;
      if (judge_kind == KIND_ADVANCED) begin
        delay_d = delay_short;
      end
      if (judge_kind == KIND_ALLOCATED) begin
        allocated_d = 1'b1;
        node_id_d   = rx_first_q[7:1];
        nid_d       = rx_first_q[7:1];
      end
    end
  end

  // Control and allocation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pref_q       <= PREFERRED_RST;
      uid_q        <= '0;
      min_q        <= MIN_PERIOD_RST;
      max_q        <= MAX_DELAY_RST;
      delay_q      <= {1'b0, MIN_PERIOD_RST};
      uid_offset_q <= '0;
      allocated_q  <= 1'b0;
      node_id_q    <= '0;
      rx_count_q   <= '0;
      rx_match_q   <= 1'b1;
      rx_first_q   <= '0;
      emit_idx_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      delay_q      <= delay_d;
      uid_offset_q <= uid_offset_d;
      allocated_q  <= allocated_d;
      node_id_q    <= node_id_d;
      rx_count_q   <= rx_count_d;
      rx_match_q   <= rx_match_d;
      rx_first_q   <= rx_first_d;
      emit_idx_q   <= emit_idx_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PREFERRED:  pref_q <= cfg_data_i[6:0];
          CFG_UID_LOW:    uid_q[63:0] <= cfg_data_i;
          CFG_UID_HIGH:   uid_q[127:64] <= cfg_data_i;
          CFG_MIN_PERIOD: min_q <= cfg_data_i[15:0];
          CFG_MAX_DELAY:  max_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: input item, product and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      type_q <= req_type_i;
      byte_q <= payload_byte_i;
      last_q <= payload_last_i;
      anon_q <= source_anonymous_i;
      rnd_q  <= random_value_i;
    end
    if (cmd_i.mul) begin
      prod_q <= rnd_q * max_q;
    end
    kind_q     <= kind_d;
    data_q     <= data_d;
    out_last_q <= out_last_d;
    nid_q      <= nid_d;
    out_off_q  <= out_off_d;
  end

  assign sts_o.allocated = allocated_q;
  assign sts_o.delay_gt1 = (delay_q > DELAY_W'(1));
  assign sts_o.is_tick   = !type_q;
  assign sts_o.is_last   = last_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.emit_last = (emit_idx_q == n_uid);

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = kind_q;
  assign data_byte_o        = data_q;
  assign last_of_run_o      = out_last_q;
  assign assigned_node_id_o = nid_q;
  assign confirmed_offset_o = out_off_q;

  `DNIA_ASSERT(a_alloc_sticky, allocated_q |=> allocated_q)
  `DNIA_NEVER(a_offset_range, uid_offset_q > OFF_W'(UID_BYTES))
  `DNIA_NEVER(a_push_full, (cmd_i.emit_push || cmd_i.judge) && out_valid_q && !out_ready_i)

endmodule

// ----- src/dynamic_node_id_allocatee.sv -----
// Top level of the dynamic node ID allocatee
//
// Channel   Direction  Handshake              Carries
// input     in         in_valid_i/in_ready_o  tick or response byte with random value
// result    out        out_valid_o/out_ready_i request bytes and status results
// config    in         cfg_we_i               register index and write data
//
// A countdown tick or a non-final response byte passes the decide state and returns to ready.
// A request emits a preferred-ID byte and then n unique ID bytes (at most 6) through the
// one-byte result register, then runs the registered multiply and reciprocal divide of the
// delay draw; a final response byte runs the multiply and divide and then the judgment.
// A stalled result holds the controller until the result register is free.
// Reset is asynchronous and needs no clearing pass.

module dynamic_node_id_allocatee import dnia_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [7:0]            payload_byte_i,
  input  logic                  payload_last_i,
  input  logic                  source_anonymous_i,
  input  logic [15:0]           random_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            result_kind_o,
  output logic [7:0]            data_byte_o,
  output logic                  last_of_run_o,
  output logic [6:0]            assigned_node_id_o,
  output logic [OFF_W-1:0]      confirmed_offset_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dnia_cmd_t cmd;
  dnia_sts_t sts;

  dnia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dnia_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .req_type_i         (req_type_i),
    .payload_byte_i     (payload_byte_i),
    .payload_last_i     (payload_last_i),
    .source_anonymous_i (source_anonymous_i),
    .random_value_i     (random_value_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .data_byte_o        (data_byte_o),
    .last_of_run_o      (last_of_run_o),
    .assigned_node_id_o (assigned_node_id_o),
    .confirmed_offset_o (confirmed_offset_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench of the dynamic node ID allocatee with random handshake stalls
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dnia_pkg::*;

  localparam bit ITEM_TICK     = 1'b0;
  localparam bit ITEM_RESPONSE = 1'b1;

  localparam longint unsigned RANDOM_SPAN = 64'hFFFF;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_PERCENT   = 13;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 58;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    bit          req_type;
    logic [7:0]  payload;
    bit          last;
    bit          anon;
    logic [15:0] rnd;
  } alloc_item_t;

  typedef struct {
    kind_e            kind;
    logic [7:0]       data;
    bit               last;
    logic [6:0]       node_id;
    logic [OFF_W-1:0] offset;
  } alloc_result_t;

  // Shadow of the allocatee plus the queue of request bytes and status results it owes
  class alloc_scoreboard;
    logic [6:0]         preferred;
    logic [UID_W-1:0]   uid;
    logic [15:0]        min_period;
    logic [15:0]        max_delay;
    logic [DELAY_W-1:0] delay_left;
    logic [OFF_W-1:0]   offset;
    bit                 allocated;
    logic [6:0]         node_id;
    logic [RX_W-1:0]    rx_count;
    bit                 rx_match;
    logic [7:0]         rx_head;
    alloc_result_t      due_outputs[$];
    int                 errors;

    function new();
      preferred  = PREFERRED_RST;
      uid        = '0;
      min_period = MIN_PERIOD_RST;
      max_delay  = MAX_DELAY_RST;
      delay_left = DELAY_W'(MIN_PERIOD_RST);
      offset     = '0;
      allocated  = 1'b0;
      node_id    = '0;
      rx_count   = '0;
      rx_match   = 1'b1;
      rx_head    = '0;
      errors     = 0;
    endfunction

    function logic [7:0] id_byte(int unsigned idx);
      return uid[idx*8 +: 8];
    endfunction

    // min period plus r scaled by max delay over the full random span
    function logic [DELAY_W-1:0] redraw(logic [15:0] r);
      longint unsigned a;
      longint unsigned b;
      a = r;
      b = max_delay;
      return DELAY_W'(longint'(min_period) + (a * b) / RANDOM_SPAN);
    endfunction

    function void push(kind_e k, logic [7:0] d, bit l, logic [6:0] nid,
                       logic [OFF_W-1:0] off);
      alloc_result_t r;
      r.kind    = k;
      r.data    = d;
      r.last    = l;
      r.node_id = nid;
      r.offset  = off;
      due_outputs.push_back(r);
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PREFERRED:  preferred = data[6:0];
        CFG_UID_LOW:    uid[63:0] = data;
        CFG_UID_HIGH:   uid[127:64] = data;
        CFG_MIN_PERIOD: min_period = data[15:0];
        CFG_MAX_DELAY:  max_delay = data[15:0];
        default: ;
      endcase
    endfunction

    // Advance the shadow by one accepted item and queue what it produces
    function void note_accepted(alloc_item_t it);
      int unsigned      n;
      int unsigned      len;
      logic [OFF_W-1:0] off;
      kind_e            k;
      logic [6:0]       nid;
      if (allocated) return;
      if (it.req_type == ITEM_TICK) begin
        if (delay_left > 1) begin
          delay_left--;
          return;
        end
        off = offset;
        n = (off < UID_BYTES) ? UID_BYTES - off : 0;
        if (n > MAX_UID_PER_REQUEST) n = MAX_UID_PER_REQUEST;
        push(KIND_REQUEST, {preferred, off == 0}, n == 0, '0, off);
        for (int unsigned i = 0; i < n; i++) begin
          push(KIND_REQUEST, id_byte(off + i), i + 1 == n, '0, off);
        end
        offset     = '0;
        delay_left = redraw(it.rnd);
        return;
      end
      // Collect one response byte
      if (rx_count == 0) begin
        rx_head = it.payload;
      end else if (rx_count - 1 < UID_BYTES && id_byte(rx_count - 1) != it.payload) begin
        rx_match = 1'b0;
      end
      if (rx_count != RX_SAT) rx_count++;
      if (!it.last) return;
      // Judge the whole payload
      len        = rx_count;
      nid        = '0;
      delay_left = redraw(it.rnd);
      if (it.anon) begin
        offset = '0;
        k      = KIND_RESET;
      end else if (len > UID_BYTES + 1) begin
        offset = '0;
        k      = KIND_MALFORMED;
      end else if (!rx_match) begin
        offset = '0;
        k      = KIND_RESET;
      end else if (len - 1 < UID_BYTES) begin
        offset     = OFF_W'(len - 1);
        delay_left = (delay_left > min_period) ? delay_left - min_period : '0;
        k          = KIND_ADVANCED;
      end else begin
        allocated = 1'b1;
        node_id   = rx_head[7:1];
        nid       = node_id;
        k         = KIND_ALLOCATED;
      end
      rx_count = '0;
      rx_match = 1'b1;
      push(k, '0, 1'b1, nid, offset);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (due_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                 $time, got.kind, got.data);
        return;
      end
      want = due_outputs.pop_front();
      compare_field("result_kind", 8'(want.kind), 8'(got.kind));
      compare_field("data_byte", want.data, got.data);
      compare_field("last_of_run", 8'(want.last), 8'(got.last));
      compare_field("assigned_node_id", 8'(want.node_id), 8'(got.node_id));
      compare_field("confirmed_offset", 8'(want.offset), 8'(got.offset));
    endfunction

    function int pending();
      return due_outputs.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  req_type_i = 1'b0;
  logic [7:0]            payload_byte_i = '0;
  logic                  payload_last_i = 1'b0;
  logic                  source_anonymous_i = 1'b0;
  logic [15:0]           random_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [2:0]            result_kind_o;
  logic [7:0]            data_byte_o;
  logic                  last_of_run_o;
  logic [6:0]            assigned_node_id_o;
  logic [OFF_W-1:0]      confirmed_offset_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  alloc_scoreboard sb;
  alloc_result_t   seen_result;
  logic [UID_W-1:0] cur_uid = '0;
  bit              calm = 1'b0;
  bit              wide_draw = 1'b0;
  bit              hold_request = 1'b0;
  int              items_sent = 0;
  int              quiet_cycles = 0;

  dynamic_node_id_allocatee uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .payload_byte_i     (payload_byte_i),
    .payload_last_i     (payload_last_i),
    .source_anonymous_i (source_anonymous_i),
    .random_value_i     (random_value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .data_byte_o        (data_byte_o),
    .last_of_run_o      (last_of_run_o),
    .assigned_node_id_o (assigned_node_id_o),
    .confirmed_offset_o (confirmed_offset_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Check every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result.kind    = kind_e'(result_kind_o);
      seen_result.data    = data_byte_o;
      seen_result.last    = last_of_run_o;
      seen_result.node_id = assigned_node_id_o;
      seen_result.offset  = confirmed_offset_o;
      sb.check_result(seen_result);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dynamic_node_id_allocatee test failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] pick_rnd();
    if (wide_draw && $urandom_range(3) != 0) return 16'($urandom_range(15));
    return 16'($urandom_range(65535));
  endfunction

  // Response payload: node ID byte followed by the first count unique ID bytes
  function automatic byte_q_t uid_prefix(int count, logic [7:0] head);
    byte_q_t q;
    q.push_back(head);
    for (int i = 0; i < count; i++) q.push_back(cur_uid[i*8 +: 8]);
    return q;
  endfunction

  task automatic send_item(alloc_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    req_type_i         <= it.req_type;
    payload_byte_i     <= it.payload;
    payload_last_i     <= it.last;
    source_anonymous_i <= it.anon;
    random_value_i     <= it.rnd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_accepted(it);
    items_sent++;
  endtask

  task automatic send_tick(logic [15:0] rnd);
    alloc_item_t it;
    it.req_type = ITEM_TICK;
    it.payload  = 8'($urandom_range(255));
    it.last     = bit'($urandom_range(1));
    it.anon     = bit'($urandom_range(1));
    it.rnd      = rnd;
    send_item(it);
  endtask

  // The source flag and random value only count on the final byte
  task automatic send_response(byte_q_t q, bit anon, logic [15:0] rnd);
    alloc_item_t it;
    foreach (q[i]) begin
      it.req_type = ITEM_RESPONSE;
      it.payload  = q[i];
      it.last     = (i == q.size() - 1);
      it.anon     = it.last ? anon : bit'($urandom_range(1));
      it.rnd      = it.last ? rnd : 16'($urandom_range(65535));
      send_item(it);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.note_config(idx, data);
  endtask

  task automatic apply_setting(logic [6:0] pref, logic [63:0] lo, logic [63:0] hi,
                               logic [15:0] min_p, logic [15:0] max_d);
    write_reg(CFG_PREFERRED, 64'(pref));
    write_reg(CFG_UID_LOW, lo);
    write_reg(CFG_UID_HIGH, hi);
    write_reg(CFG_MIN_PERIOD, 64'(min_p));
    write_reg(CFG_MAX_DELAY, 64'(max_d));
    cfg_we_i <= 1'b0;
    cur_uid = {hi, lo};
  endtask

  // Drain all owed results, then let the block finish any silent work
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One random stimulus sequence: mostly ticks and well-formed responses
  task automatic random_step();
    int      sel;
    int      k;
    int      pos;
    byte_q_t q;
    sel = $urandom_range(99);
    if (sel < 50) begin
      repeat ($urandom_range(1, 6)) send_tick(pick_rnd());
    end else if (sel < 82) begin
      k = $urandom_range(15);
      send_response(uid_prefix(k, 8'($urandom_range(255))), $urandom_range(9) == 0,
                    pick_rnd());
    end else if (sel < 94) begin
      // corrupt one unique ID byte
      k = $urandom_range(1, 16);
      q = uid_prefix(k, 8'($urandom_range(255)));
      pos = $urandom_range(1, k);
      q[pos] = q[pos] ^ 8'($urandom_range(1, 255));
      send_response(q, $urandom_range(19) == 0, pick_rnd());
    end else begin
      // overlong payload, past the receive counter saturation at times
      q = uid_prefix(16, 8'($urandom_range(255)));
      repeat ($urandom_range(1, 17)) q.push_back(8'($urandom_range(255)));
      send_response(q, $urandom_range(9) == 0, pick_rnd());
    end
  endtask

  initial begin
    byte_q_t q;
    int      phase_end;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: top preferred ID, all-ones low half, zero period and delay
    apply_setting(7'd127, '1, '0, 16'd0, 16'd0);
    send_tick(16'd0);
    send_response(uid_prefix(0, 8'hFF), 1'b0, 16'hFFFF);
    send_tick(16'd0);
    send_response(uid_prefix(2, 8'h00), 1'b0, 16'd0);
    send_tick(16'hFFFF);
    send_response(uid_prefix(3, 8'h80), 1'b1, 16'd0);
    q = uid_prefix(1, 8'h01);
    q[1] = ~q[1];
    send_response(q, 1'b0, 16'd0);

    // Directed: largest delay draw, zero preferred ID
    settle();
    apply_setting(7'd0, rand64(), '1, 16'hFFFF, 16'hFFFF);
    send_response(uid_prefix(0, 8'h00), 1'b0, 16'hFFFF);
    send_tick(16'd0);
    send_response(uid_prefix(1, 8'hFE), 1'b0, 16'd0);
    send_tick(16'd0);
    send_response(uid_prefix(0, 8'h55), 1'b0, 16'd0);
    send_tick(16'hFFFF);

    // Random phases, each under its own setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph)
        2: apply_setting(7'($urandom_range(127)), '0, '1, 16'd1, 16'd0);
        3: apply_setting(7'($urandom_range(127)), rand64(), rand64(),
                         16'($urandom_range(3)), 16'hFFFF);
        4: apply_setting(7'd0, rand64(), rand64(), 16'd0, 16'd0);
        default: apply_setting(7'($urandom_range(127)), rand64(), rand64(),
                               16'($urandom_range(4)), 16'($urandom_range(8)));
      endcase
      calm      = (ph == 1);
      wide_draw = (ph == 3);
      if (ph == 0) hold_request = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      // redraw the delay left over from the previous setting
      send_response(uid_prefix(0, 8'($urandom_range(255))), 1'b0, pick_rnd());
      while (items_sent < phase_end) random_step();
    end

    // Full match latches the node ID; everything after it is ignored
    send_response(uid_prefix(16, 8'($urandom_range(255))), 1'b0, pick_rnd());
    repeat (3) send_tick(pick_rnd());
    send_response(uid_prefix(2, 8'($urandom_range(255))), 1'b0, pick_rnd());

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("dynamic_node_id_allocatee test passed");
    end else begin
      $display("dynamic_node_id_allocatee test failed");
    end
    $finish;
  end

endmodule
